// ===== sv/assert_macros.svh =====
// shared assertion macros, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every rising edge of clk_i
`define QMN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("qmn assertion failed");

// same-cycle implication
`define QMN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qmn implication failed");

`endif

// ===== sv/qmn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qmn_pkg;

  localparam int unsigned CompBits = 16;
  localparam int unsigned FracBits = CompBits - 2;
  localparam int unsigned ProdBits = 2 * CompBits;
  localparam int unsigned PBits    = ProdBits + 2;
  localparam int unsigned MagBits  = ProdBits + 1;
  localparam int unsigned PosBits  = $clog2(MagBits);
  localparam int unsigned NormTop  = 29;
  localparam int unsigned NormBits = NormTop + 1;
  localparam int unsigned SqBits   = 2 * NormBits;
  localparam int unsigned SumBits  = SqBits + 2;
  localparam int unsigned RootBits = NormBits + 1;
  localparam int unsigned NumBits  = NormBits + FracBits + 1;
  localparam int unsigned QuotBits = FracBits + 1;

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [3:0] neg;
  } ctl_t;

  typedef logic [3:0][NormBits-1:0] norm4_t;

endpackage

`default_nettype wire

// ===== sv/quaternion_multiply_normalize_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   a_x_i a_y_i a_z_i a_s_i b_x_i b_y_i b_z_i b_s_i
// out      output     out_valid_o / out_stall_i out_x_o out_y_o out_z_o out_s_o zero_length_o
//
// one transaction per cycle sustained while in_stall_o is low; 56 register stages
// depth is set by the square root (one root bit per stage) and the dividers (one
// quotient bit per stage)
// reset clears every valid bit in the pipeline, the output register and the skid slot
// a stalled output parks the next result in the skid slot; in_stall_o is that slot's
// full flag, so the input side only stalls after two results are waiting
module quaternion_multiply_normalize_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic signed [15:0]  a_x_i,
  input  wire logic signed [15:0]  a_y_i,
  input  wire logic signed [15:0]  a_z_i,
  input  wire logic signed [15:0]  a_s_i,
  input  wire logic signed [15:0]  b_x_i,
  input  wire logic signed [15:0]  b_y_i,
  input  wire logic signed [15:0]  b_z_i,
  input  wire logic signed [15:0]  b_s_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [15:0]       out_x_o,
  output logic signed [15:0]       out_y_o,
  output logic signed [15:0]       out_z_o,
  output logic signed [15:0]       out_s_o,
  output logic                     zero_length_o
);

  typedef struct packed {
    logic [3:0][qmn_pkg::CompBits-1:0] comp;
    logic                              zero;
  } res_t;

  localparam logic [qmn_pkg::QuotBits-1:0] One = qmn_pkg::QuotBits'(1 << qmn_pkg::FracBits);

  logic adv;

  // stage 1: operands, index 0..3 = x y z s
  logic                                v1_q;
  logic signed [qmn_pkg::CompBits-1:0] a_q [4];
  logic signed [qmn_pkg::CompBits-1:0] b_q [4];
  // stage 2: all sixteen products, index 4*i+j = a_i * b_j
  logic                                v2_q;
  logic signed [qmn_pkg::ProdBits-1:0] pr_q [16];
  // stage 3: product components
  logic                                v3_q;
  logic signed [qmn_pkg::PBits-1:0]    p_q [4];
  // stage 4: magnitudes and their or
  qmn_pkg::ctl_t                       c4_q;
  logic [qmn_pkg::MagBits-1:0]         m4_q [4];
  logic [qmn_pkg::MagBits-1:0]         orv_q;
  // stage 5: leading one position
  qmn_pkg::ctl_t                       c5_q;
  logic [qmn_pkg::MagBits-1:0]         m5_q [4];
  logic [qmn_pkg::PosBits-1:0]         pos_d, pos_q;
  // stage 6: normalized magnitudes
  qmn_pkg::ctl_t                       c6_q;
  qmn_pkg::norm4_t                     n6_q;
  // stage 7: squares
  qmn_pkg::ctl_t                       c7_q;
  qmn_pkg::norm4_t                     n7_q;
  logic [qmn_pkg::SqBits-1:0]          sq_q [4];
  // stage 8: sum of squares
  qmn_pkg::ctl_t                       c8_q;
  qmn_pkg::norm4_t                     n8_q;
  logic [qmn_pkg::SumBits-1:0]         sum_q;
  // after the root
  logic [qmn_pkg::RootBits-1:0]        root;
  qmn_pkg::ctl_t                       c_rt;
  qmn_pkg::norm4_t                     n_rt;
  // dividend stage
  qmn_pkg::ctl_t                       cn_q;
  logic [qmn_pkg::NumBits-1:0]         num_q [4];
  logic [qmn_pkg::RootBits-1:0]        den_q;
  // divider delay line for control
  qmn_pkg::ctl_t                       cd_q [qmn_pkg::QuotBits];
  logic [qmn_pkg::QuotBits-1:0]        quot [4];
  // output side
  res_t                                tail;
  logic                                out_v_q, skid_v_q, out_free;
  res_t                                out_q, skid_q;

  assign adv = !skid_v_q;

  function automatic logic signed [qmn_pkg::PBits-1:0] ext(
    input logic signed [qmn_pkg::ProdBits-1:0] v
  );
    return qmn_pkg::PBits'(v);
  endfunction

  // msb of the or is the msb of the largest magnitude
  always_comb begin
    pos_d = '0;
    for (int k = 0; k < qmn_pkg::MagBits; k++) begin
      if (orv_q[k]) begin
        pos_d = qmn_pkg::PosBits'(k);
      end
    end
  end

  // control path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
      c7_q <= '0;
      c8_q <= '0;
      cn_q <= '0;
      for (int k = 0; k < qmn_pkg::QuotBits; k++) begin
        cd_q[k] <= '0;
      end
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      c4_q.valid <= v3_q;
      c4_q.zero  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        c4_q.neg[i] <= p_q[i][qmn_pkg::PBits-1];
      end
      c5_q <= '{valid: c4_q.valid, zero: (orv_q == '0), neg: c4_q.neg};
      c6_q <= c5_q;
      c7_q <= c6_q;
      c8_q <= c7_q;
      cn_q <= c_rt;
      cd_q[0] <= cn_q;
      for (int k = 1; k < qmn_pkg::QuotBits; k++) begin
        cd_q[k] <= cd_q[k-1];
      end
    end
  end

  // data path
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q[0] <= a_x_i;
      a_q[1] <= a_y_i;
      a_q[2] <= a_z_i;
      a_q[3] <= a_s_i;
      b_q[0] <= b_x_i;
      b_q[1] <= b_y_i;
      b_q[2] <= b_z_i;
      b_q[3] <= b_s_i;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr_q[4*i+j] <= a_q[i] * b_q[j];
        end
      end
      p_q[0] <= ext(pr_q[12]) + ext(pr_q[3]) + ext(pr_q[6]) - ext(pr_q[9]);
      p_q[1] <= ext(pr_q[13]) + ext(pr_q[7]) + ext(pr_q[8]) - ext(pr_q[2]);
      p_q[2] <= ext(pr_q[14]) + ext(pr_q[11]) + ext(pr_q[1]) - ext(pr_q[4]);
      p_q[3] <= ext(pr_q[15]) - ext(pr_q[0]) - ext(pr_q[5]) - ext(pr_q[10]);
      for (int i = 0; i < 4; i++) begin
        m4_q[i] <= p_q[i][qmn_pkg::PBits-1] ? qmn_pkg::MagBits'(-p_q[i])
                                            : qmn_pkg::MagBits'(p_q[i]);
      end
      orv_q <= qmn_pkg::MagBits'(
                 (p_q[0][qmn_pkg::PBits-1] ? -p_q[0] : p_q[0]) |
                 (p_q[1][qmn_pkg::PBits-1] ? -p_q[1] : p_q[1]) |
                 (p_q[2][qmn_pkg::PBits-1] ? -p_q[2] : p_q[2]) |
                 (p_q[3][qmn_pkg::PBits-1] ? -p_q[3] : p_q[3]));
      m5_q  <= m4_q;
      pos_q <= pos_d;
      for (int i = 0; i < 4; i++) begin
        n6_q[i] <= qmn_pkg::NormBits'(
                     {m5_q[i], {qmn_pkg::NormTop{1'b0}}} >> pos_q);
        sq_q[i] <= n6_q[i] * n6_q[i];
      end
      n7_q  <= n6_q;
      n8_q  <= n7_q;
      sum_q <= qmn_pkg::SumBits'(sq_q[0]) + qmn_pkg::SumBits'(sq_q[1])
             + qmn_pkg::SumBits'(sq_q[2]) + qmn_pkg::SumBits'(sq_q[3]);
      for (int i = 0; i < 4; i++) begin
        // rounded dividend: m * 2^frac + floor(n / 2)
        num_q[i] <= ({{1'b0}, n_rt[i], {qmn_pkg::FracBits{1'b0}}})
                  + qmn_pkg::NumBits'(root >> 1);
      end
      den_q <= root;
    end
  end

  qmn_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .sum_i  (sum_q),
    .ctl_i  (c8_q),
    .mag_i  (n8_q),
    .root_o (root),
    .ctl_o  (c_rt),
    .mag_o  (n_rt)
  );

  for (genvar i = 0; i < 4; i++) begin : g_div
    qmn_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (num_q[i]),
      .den_i  (den_q),
      .quot_o (quot[i])
    );
  end

  always_comb begin
    logic [qmn_pkg::QuotBits-1:0] qc;
    logic [qmn_pkg::CompBits-1:0] val;
    tail.zero = cd_q[qmn_pkg::QuotBits-1].zero;
    for (int i = 0; i < 4; i++) begin
      qc  = (quot[i] > One) ? One : quot[i];
      val = qmn_pkg::CompBits'(qc);
      if (tail.zero) begin
        tail.comp[i] = '0;
      end else if (cd_q[qmn_pkg::QuotBits-1].neg[i]) begin
        tail.comp[i] = -val;
      end else begin
        tail.comp[i] = val;
      end
    end
  end

  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || cd_q[qmn_pkg::QuotBits-1].valid;
      skid_v_q <= 1'b0;
    end else if (adv && cd_q[qmn_pkg::QuotBits-1].valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : tail;
    end else if (adv) begin
      skid_q <= tail;
    end
  end

  assign in_stall_o    = skid_v_q;
  assign out_valid_o   = out_v_q;
  assign out_x_o       = out_q.comp[0];
  assign out_y_o       = out_q.comp[1];
  assign out_z_o       = out_q.comp[2];
  assign out_s_o       = out_q.comp[3];
  assign zero_length_o = out_q.zero;

  logic range_ok;
  assign range_ok = (out_x_o >= -16'sd16384) && (out_x_o <= 16'sd16384)
                 && (out_y_o >= -16'sd16384) && (out_y_o <= 16'sd16384)
                 && (out_z_o >= -16'sd16384) && (out_z_o <= 16'sd16384)
                 && (out_s_o >= -16'sd16384) && (out_s_o <= 16'sd16384);

  `QMN_ASSERT_IMP(a_skid_needs_out, skid_v_q, out_v_q)
  `QMN_ASSERT_IMP(a_zero_clears, out_v_q && zero_length_o, out_q.comp == '0)
  `QMN_ASSERT_IMP(a_unit_range, out_v_q, range_ok)

endmodule

`default_nettype wire

// ===== sv/qmn_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring square root, one root bit per register stage
module qmn_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic [qmn_pkg::SumBits-1:0]   sum_i,
  input  wire qmn_pkg::ctl_t                 ctl_i,
  input  wire qmn_pkg::norm4_t               mag_i,
  output logic      [qmn_pkg::RootBits-1:0]  root_o,
  output qmn_pkg::ctl_t                      ctl_o,
  output qmn_pkg::norm4_t                    mag_o
);

  logic [qmn_pkg::SumBits-1:0]  rem_s  [qmn_pkg::RootBits];
  logic [qmn_pkg::SumBits-1:0]  rem_q  [qmn_pkg::RootBits-1];
  logic [qmn_pkg::RootBits-1:0] root_s [qmn_pkg::RootBits+1];
  logic [qmn_pkg::RootBits-1:0] root_q [qmn_pkg::RootBits];
  qmn_pkg::ctl_t                ctl_s  [qmn_pkg::RootBits+1];
  qmn_pkg::ctl_t                ctl_q  [qmn_pkg::RootBits];
  qmn_pkg::norm4_t              mag_s  [qmn_pkg::RootBits+1];
  qmn_pkg::norm4_t              mag_q  [qmn_pkg::RootBits];

  assign rem_s[0]  = sum_i;
  assign root_s[0] = '0;
  assign ctl_s[0]  = ctl_i;
  assign mag_s[0]  = mag_i;

  for (genvar j = 0; j < qmn_pkg::RootBits; j++) begin : g_stage
    localparam int unsigned K = qmn_pkg::RootBits - 1 - j;
    logic [63:0] trial;
    logic        take;

    // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
    assign trial = ({{(64-qmn_pkg::RootBits){1'b0}}, root_s[j]} << (K + 1))
                 + (64'd1 << (2 * K));
    assign take  = {{(64-qmn_pkg::SumBits){1'b0}}, rem_s[j]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j] <= '0;
      end else if (en_i) begin
        ctl_q[j] <= ctl_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j] <= take ? (root_s[j] | (qmn_pkg::RootBits'(1) << K)) : root_s[j];
        mag_q[j]  <= mag_s[j];
      end
    end

    if (j < qmn_pkg::RootBits - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? (rem_s[j] - trial[qmn_pkg::SumBits-1:0]) : rem_s[j];
        end
      end
      assign rem_s[j+1] = rem_q[j];
    end

    assign root_s[j+1] = root_q[j];
    assign ctl_s[j+1]  = ctl_q[j];
    assign mag_s[j+1]  = mag_q[j];
  end

  assign root_o = root_s[qmn_pkg::RootBits];
  assign ctl_o  = ctl_s[qmn_pkg::RootBits];
  assign mag_o  = mag_s[qmn_pkg::RootBits];

endmodule

`default_nettype wire

// ===== sv/qmn_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider lane, one quotient bit per register stage
module qmn_div (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [qmn_pkg::NumBits-1:0]   num_i,
  input  wire logic [qmn_pkg::RootBits-1:0]  den_i,
  output logic      [qmn_pkg::QuotBits-1:0]  quot_o
);

  logic [qmn_pkg::NumBits-1:0]  rem_s  [qmn_pkg::QuotBits];
  logic [qmn_pkg::NumBits-1:0]  rem_q  [qmn_pkg::QuotBits-1];
  logic [qmn_pkg::RootBits-1:0] den_s  [qmn_pkg::QuotBits];
  logic [qmn_pkg::RootBits-1:0] den_q  [qmn_pkg::QuotBits-1];
  logic [qmn_pkg::QuotBits-1:0] quot_s [qmn_pkg::QuotBits+1];
  logic [qmn_pkg::QuotBits-1:0] quot_q [qmn_pkg::QuotBits];

  assign rem_s[0]  = num_i;
  assign den_s[0]  = den_i;
  assign quot_s[0] = '0;

  for (genvar j = 0; j < qmn_pkg::QuotBits; j++) begin : g_stage
    localparam int unsigned K = qmn_pkg::QuotBits - 1 - j;
    logic [qmn_pkg::NumBits:0] dsh;
    logic                      take;

    // quotient stays below 2^QuotBits, so rem < den * 2^(k+1) at each step
    assign dsh  = {{(qmn_pkg::NumBits+1-qmn_pkg::RootBits){1'b0}}, den_s[j]} << K;
    assign take = {1'b0, rem_s[j]} >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[j] <= take ? (quot_s[j] | (qmn_pkg::QuotBits'(1) << K)) : quot_s[j];
      end
    end
    assign quot_s[j+1] = quot_q[j];

    if (j < qmn_pkg::QuotBits - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? (rem_s[j] - dsh[qmn_pkg::NumBits-1:0]) : rem_s[j];
          den_q[j] <= den_s[j];
        end
      end
      assign rem_s[j+1] = rem_q[j];
      assign den_s[j+1] = den_q[j];
    end
  end

  assign quot_o = quot_s[qmn_pkg::QuotBits];

endmodule

`default_nettype wire
